FILE: hdl/rvr_pkg.sv
`default_nettype none
package rvr_pkg;
    localparam int WINDOW  = 50;
    localparam int AW      = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int RET_W   = 32;
    localparam int DUR_W   = 40;
    localparam int MEM_W   = RET_W + DUR_W;
    localparam int S1_W    = RET_W + CNT_W;
    localparam int DSUM_W  = DUR_W + CNT_W;
    localparam int SQS_W   = 64 + CNT_W;
    localparam int RNUM_W  = 46 + CNT_W;
    localparam int DIV_NW  = (SQS_W > 57) ? SQS_W : 57;
    localparam int DEN_W   = (DSUM_W > 32) ? DSUM_W : 32;
    localparam int DCNT_W  = $clog2(DIV_NW + 1);
    localparam int RATE_W  = 48;

    localparam logic [45:0]       RATE_SCALE = 46'd65536000000000;
    localparam logic [DUR_W-1:0]  DUR_MAX    = {DUR_W{1'b1}};
    localparam logic [DUR_W-1:0]  DUR_ZERO   = DUR_W'(1000000);
    localparam logic [15:0]       EMA_W_RST  = 16'd655;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_RET  = 11'b000_0000_0010,
        S_WR   = 11'b000_0000_0100,
        S_P1   = 11'b000_0000_1000,
        S_MEAN = 11'b000_0001_0000,
        S_P2   = 11'b000_0010_0000,
        S_VAR  = 11'b000_0100_0000,
        S_SQRT = 11'b000_1000_0000,
        S_RATE = 11'b001_0000_0000,
        S_EMA  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;
endpackage
`default_nettype wire

FILE: hdl/rolling_volatility_regime_top.sv
// Rolling volatility / event-intensity regime detector. Each input transfer
// carries a mid price and a nanosecond timestamp; each produces one output
// transfer. While the stored price is zero the input is only recorded
// (tuser = 0, all data zero). Otherwise the return and elapsed time go into
// a WINDOW-entry RAM, which is then swept twice (sum, then squared
// deviations). One shared restoring divider (one quotient bit per cycle)
// handles the return, mean, variance and rate; a bit-pair square root
// takes the root of the variance. A primed result passes through the return
// divide, the window write, the two sweeps, the mean and variance divides,
// the root, the rate divide, the EMA and the output register. A full output
// register holds the item until the result is taken. Input is taken only
// while no item is in progress; it is ready again in the cycle the result is
// presented. ema_weight is written over the cfg port; the user must write it
// only while idle, as the block itself does not enforce this.
`default_nettype none
module rolling_volatility_regime_top
    import rvr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [95:0]  i_s_axis_tdata,   // price[31:0], time in ns[95:32]
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic      [167:0] o_m_axis_tdata,   // volatility[31:0], intensity[79:32],
                                                // vol baseline[111:80],
                                                // rate baseline[159:112], regime[161:160]
    output logic              o_m_axis_tuser    // primed
);
    t_state r_state;

    logic [15:0]        r_ema_w;
    logic [31:0]        r_last_price;
    logic [63:0]        r_last_time;
    logic [31:0]        r_mid;
    logic [63:0]        r_ts;
    logic [CNT_W-1:0]   r_count;
    logic [AW-1:0]      r_head;
    logic [31:0]        r_cur_vol;
    logic [RATE_W-1:0]  r_cur_rate;
    logic [31:0]        r_base_vol;
    logic [RATE_W-1:0]  r_base_rate;
    logic               r_primed;

    logic               r_neg;
    logic [RET_W-1:0]   r_ret;
    logic [DUR_W-1:0]   r_dur;

    // window sweep
    logic [AW-1:0]      r_rd_idx;
    logic               r_issue_done;
    logic               r_rd_vld;
    logic [S1_W-1:0]    r_s1;
    logic [DSUM_W-1:0]  r_dsum;
    logic [31:0]        r_mean;
    logic [63:0]        r_sq;
    logic               r_sq_vld;
    logic [SQS_W-1:0]   r_sqsum;

    // shared divider
    logic [DIV_NW-1:0]  r_dnum;
    logic [DIV_NW-1:0]  r_dquo;
    logic [DEN_W-1:0]   r_dden;
    logic [DEN_W-1:0]   r_drem;
    logic [DCNT_W-1:0]  r_dcnt;

    // square root
    logic [63:0]        r_sx;
    logic [63:0]        r_sres;
    logic [63:0]        r_sbit;
    logic [5:0]         r_scnt;

    // ema
    logic [2:0]         r_eph;
    logic [64:0]        r_p0;
    logic [64:0]        r_p1;

    logic               r_out_vld;
    logic [167:0]       r_out_data;
    logic               r_out_user;

    logic               s_accept;
    logic [32:0]        s_diff;
    logic [32:0]        s_mag;
    logic [63:0]        s_dlt;
    logic [DUR_W-1:0]   s_dur;
    logic [DEN_W:0]     s_rem_sh;
    logic               s_ge;
    logic [DEN_W:0]     s_rem_sub;
    logic [64:0]        s_root_try;
    logic               s_root_ge;
    logic [56:0]        s_qm;
    logic [S1_W-1:0]    s_s1_mag;
    logic [32:0]        s_d;
    logic [32:0]        s_dabs;
    logic [65:0]        s_sq;
    logic [RNUM_W-1:0]  s_rnum;
    logic [16:0]        s_inv_w;
    logic [47:0]        s_ma;
    logic [16:0]        s_mb;
    logic [64:0]        s_prod;
    logic [65:0]        s_esum;
    logic [47:0]        s_eres;
    logic [RET_W-1:0]   s_rd_ret;
    logic [DUR_W-1:0]   s_rd_dur;
    logic [MEM_W-1:0]   s_rdata;
    logic [MEM_W-1:0]   s_rdata_q;
    logic               s_we;
    logic               s_re;
    logic               s_last_issue;
    logic [1:0]         s_regime;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    always_comb begin
        s_diff = {1'b0, i_s_axis_tdata[31:0]} - {1'b0, r_last_price};
        s_mag  = s_diff[32] ? (~s_diff + 33'd1) : s_diff;
        s_dlt  = i_s_axis_tdata[95:32] - r_last_time;
        if (s_dlt == 64'd0) begin
            s_dur = DUR_ZERO;
        end else if (|s_dlt[63:DUR_W]) begin
            s_dur = DUR_MAX;
        end else begin
            s_dur = s_dlt[DUR_W-1:0];
        end
    end

    // divider step: one quotient bit
    always_comb begin
        s_rem_sh  = {r_drem, r_dnum[DIV_NW-1]};
        s_ge      = s_rem_sh >= {1'b0, r_dden};
        s_rem_sub = s_rem_sh - {1'b0, r_dden};
    end

    assign s_root_try = {1'b0, r_sres} + {1'b0, r_sbit};
    assign s_root_ge  = {1'b0, r_sx} >= s_root_try;

    assign s_qm     = r_dquo[56:0];
    assign s_s1_mag = r_s1[S1_W-1] ? (~r_s1 + S1_W'(1)) : r_s1;

    assign s_rdata  = s_rdata_q;
    assign s_rd_ret = s_rdata[RET_W-1:0];
    assign s_rd_dur = s_rdata[MEM_W-1:RET_W];

    always_comb begin
        s_d    = {s_rd_ret[RET_W-1], s_rd_ret} - {r_mean[31], r_mean};
        s_dabs = s_d[32] ? (~s_d + 33'd1) : s_d;
        s_sq   = s_dabs * s_dabs;
    end

    assign s_rnum = RNUM_W'(RATE_SCALE) * RNUM_W'(r_count);

    // shared EMA multiplier
    always_comb begin
        s_inv_w = 17'd65536 - {1'b0, r_ema_w};
        case (r_eph)
            3'd0:    begin s_ma = {16'd0, r_base_vol}; s_mb = s_inv_w;         end
            3'd1:    begin s_ma = {16'd0, r_cur_vol};  s_mb = {1'b0, r_ema_w}; end
            3'd3:    begin s_ma = r_base_rate;         s_mb = s_inv_w;         end
            3'd4:    begin s_ma = r_cur_rate;          s_mb = {1'b0, r_ema_w}; end
            default: begin s_ma = '0;                  s_mb = '0;              end
        endcase
        s_prod = s_ma * s_mb;
        s_esum = {1'b0, r_p0} + {1'b0, r_p1} + 66'd32768;
        s_eres = s_esum[63:16];
    end

    assign s_regime = {r_cur_vol > r_base_vol, r_cur_rate > r_base_rate};

    assign s_we         = (r_state == S_WR);
    assign s_re         = ((r_state == S_P1) || (r_state == S_P2)) && !r_issue_done;
    assign s_last_issue = (CNT_W'(r_rd_idx) == (r_count - CNT_W'(1)));

    rvr_ram #(
        .WIDTH (MEM_W),
        .DEPTH (WINDOW)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_head),
        .i_wdata ({r_dur, r_ret}),
        .i_re    (s_re),
        .i_raddr (r_rd_idx),
        .o_rdata (s_rdata_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ema_w      <= EMA_W_RST;
            r_last_price <= '0;
            r_last_time  <= '0;
            r_count      <= '0;
            r_head       <= '0;
            r_cur_vol    <= '0;
            r_cur_rate   <= '0;
            r_base_vol   <= '0;
            r_base_rate  <= '0;
            r_out_vld    <= 1'b0;
            r_dcnt       <= '0;
            r_scnt       <= '0;
            r_rd_vld     <= 1'b0;
            r_sq_vld     <= 1'b0;
            r_issue_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ema_w <= i_cfg_wdata;
            end
            if (r_out_vld && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end

            if (r_dcnt != '0) begin
                r_drem <= s_ge ? s_rem_sub[DEN_W-1:0] : s_rem_sh[DEN_W-1:0];
                r_dquo <= {r_dquo[DIV_NW-2:0], s_ge};
                r_dnum <= {r_dnum[DIV_NW-2:0], 1'b0};
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end

            if (r_scnt != '0) begin
                if (s_root_ge) begin
                    r_sx   <= r_sx - s_root_try[63:0];
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
                r_scnt <= r_scnt - 6'd1;
            end

            // window read pipeline
            if (s_re) begin
                r_rd_idx <= r_rd_idx + AW'(1);
                if (s_last_issue) begin
                    r_issue_done <= 1'b1;
                end
            end
            r_rd_vld <= s_re;

            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_mid <= i_s_axis_tdata[31:0];
                        r_ts  <= i_s_axis_tdata[95:32];
                        if (r_last_price == '0) begin
                            r_last_price <= i_s_axis_tdata[31:0];
                            r_last_time  <= i_s_axis_tdata[95:32];
                            r_primed     <= 1'b0;
                            r_state      <= S_DONE;
                        end else begin
                            r_primed <= 1'b1;
                            r_neg    <= s_diff[32];
                            r_dur    <= s_dur;
                            r_dnum   <= {s_mag, 24'd0, {(DIV_NW-57){1'b0}}};
                            r_dden   <= DEN_W'(r_last_price);
                            r_drem   <= '0;
                            r_dcnt   <= DCNT_W'(57);
                            r_state  <= S_RET;
                        end
                    end
                end
                S_RET: begin
                    if (r_dcnt == '0) begin
                        if (r_neg) begin
                            r_ret <= (s_qm > 57'h8000_0000) ? 32'h8000_0000
                                                           : (~s_qm[31:0] + 32'd1);
                        end else begin
                            r_ret <= (|s_qm[56:31]) ? 32'h7FFF_FFFF : s_qm[31:0];
                        end
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_head       <= (r_head == AW'(WINDOW - 1)) ? '0 : r_head + AW'(1);
                    if (r_count != CNT_W'(WINDOW)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_last_price <= r_mid;
                    r_last_time  <= r_ts;
                    r_rd_idx     <= '0;
                    r_issue_done <= 1'b0;
                    r_s1         <= '0;
                    r_dsum       <= '0;
                    r_state      <= S_P1;
                end
                S_P1: begin
                    if (r_rd_vld) begin
                        r_s1   <= r_s1 + {{(S1_W-RET_W){s_rd_ret[RET_W-1]}}, s_rd_ret};
                        r_dsum <= r_dsum + DSUM_W'(s_rd_dur);
                    end
                    if (r_issue_done && !r_rd_vld) begin
                        r_dnum  <= {s_s1_mag, {(DIV_NW-S1_W){1'b0}}};
                        r_dden  <= DEN_W'(r_count);
                        r_drem  <= '0;
                        r_dcnt  <= DCNT_W'(S1_W);
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (r_dcnt == '0) begin
                        r_mean       <= r_s1[S1_W-1] ? (~r_dquo[31:0] + 32'd1) : r_dquo[31:0];
                        r_rd_idx     <= '0;
                        r_issue_done <= 1'b0;
                        r_sqsum      <= '0;
                        r_state      <= S_P2;
                    end
                end
                S_P2: begin
                    r_sq_vld <= r_rd_vld;
                    if (r_rd_vld) begin
                        r_sq <= s_sq[63:0];
                    end
                    if (r_sq_vld) begin
                        r_sqsum <= r_sqsum + SQS_W'(r_sq);
                    end
                    if (r_issue_done && !r_rd_vld && !r_sq_vld) begin
                        r_dnum  <= DIV_NW'(r_sqsum) << (DIV_NW - SQS_W);
                        r_dden  <= DEN_W'(r_count);
                        r_drem  <= '0;
                        r_dcnt  <= DCNT_W'(SQS_W);
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (r_dcnt == '0) begin
                        r_sx    <= (|r_dquo[SQS_W-1:64]) ? {64{1'b1}} : r_dquo[63:0];
                        r_sres  <= '0;
                        r_sbit  <= 64'h4000_0000_0000_0000;
                        r_scnt  <= 6'd32;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_scnt == '0) begin
                        r_cur_vol <= r_sres[31:0];
                        r_dnum    <= {s_rnum, {(DIV_NW-RNUM_W){1'b0}}};
                        r_dden    <= DEN_W'(r_dsum);
                        r_drem    <= '0;
                        r_dcnt    <= (r_dsum == '0) ? '0 : DCNT_W'(RNUM_W);
                        r_dquo    <= '0;
                        r_state   <= S_RATE;
                    end
                end
                S_RATE: begin
                    if (r_dcnt == '0) begin
                        r_cur_rate <= (|r_dquo[RNUM_W-1:RATE_W]) ? {RATE_W{1'b1}}
                                                                : r_dquo[RATE_W-1:0];
                        r_eph      <= 3'd0;
                        r_state    <= S_EMA;
                    end
                end
                S_EMA: begin
                    r_eph <= r_eph + 3'd1;
                    case (r_eph)
                        3'd0, 3'd3: r_p0 <= s_prod;
                        3'd1, 3'd4: r_p1 <= s_prod;
                        3'd2: begin
                            r_base_vol <= (r_base_vol == '0) ? r_cur_vol : s_eres[31:0];
                        end
                        default: begin
                            r_base_rate <= (r_base_rate == '0) ? r_cur_rate : s_eres;
                            r_state     <= S_DONE;
                        end
                    endcase
                end
                S_DONE: begin
                    if (!r_out_vld || i_m_axis_tready) begin
                        r_out_vld  <= 1'b1;
                        r_out_user <= r_primed;
                        if (r_primed) begin
                            r_out_data <= {6'd0, s_regime, r_base_rate, r_base_vol,
                                           r_cur_rate, r_cur_vol};
                        end else begin
                            r_out_data <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/rvr_ram.sv
`default_nettype none
module rvr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none
module tb_top;
    import rvr_pkg::*;

    typedef struct packed {
        logic        primed;
        logic [31:0] vol;
        logic [47:0] rate;
        logic [31:0] avg_vol;
        logic [47:0] avg_rate;
        logic [1:0]  regime;
    } t_metrics;

    localparam int NWIN = WINDOW;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [15:0]  i_cfg_wdata;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [95:0]  i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [167:0] o_m_axis_tdata;
    logic         o_m_axis_tuser;

    rolling_volatility_regime_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // predictor state
    logic [15:0]          weight;
    logic [31:0]          prev_price;
    logic [63:0]          prev_time;
    logic signed [31:0]   ret_hist [NWIN];
    logic [39:0]          dur_hist [NWIN];
    int                   fill;
    int                   head;
    logic [31:0]          base_vol;
    logic [47:0]          base_rate;

    t_metrics expected_q[$];
    int       errors = 0;
    bit       idle_en = 1'b0;

    function automatic logic [63:0] sqrt_floor(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [47:0] ema_next(logic [47:0] b, logic [47:0] c);
        logic [79:0] acc;
        if (b == 0) return c;
        acc = 80'(b) * (80'd65536 - 80'(weight)) + 80'(c) * 80'(weight) + 80'd32768;
        return acc[63:16];
    endfunction

    function automatic t_metrics predict_metrics(logic [31:0] mid, logic [63:0] ts);
        t_metrics m;
        logic signed [63:0]  q, s1, mean, d;
        logic [63:0]         dur, dsum, a;
        logic [127:0]        sqsum, var128, num;
        logic [63:0]         var64, v;
        logic [127:0]        rate;
        m = '0;
        if (prev_price == 0) begin
            prev_price = mid;
            prev_time = ts;
            return m;
        end
        q = ((signed'({32'd0, mid}) - signed'({32'd0, prev_price})) * 64'sd16777216)
            / signed'({32'd0, prev_price});
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        dur = ts - prev_time;
        if (dur == 0) dur = 64'd1000000;
        if (dur > 64'hFF_FFFF_FFFF) dur = 64'hFF_FFFF_FFFF;
        ret_hist[head] = q[31:0];
        dur_hist[head] = dur[39:0];
        head = (head + 1) % NWIN;
        if (fill < NWIN) fill++;
        s1 = 0;
        dsum = 0;
        for (int i = 0; i < fill; i++) begin
            s1 += 64'(ret_hist[i]);
            dsum += 64'(dur_hist[i]);
        end
        mean = s1 / fill;
        sqsum = 0;
        for (int i = 0; i < fill; i++) begin
            d = 64'(ret_hist[i]) - mean;
            a = d < 0 ? -d : d;
            sqsum += 128'(a) * 128'(a);
        end
        var128 = sqsum / fill;
        var64 = (var128 > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : var128[63:0];
        v = sqrt_floor(var64);
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        num = 128'd65536000000000 * fill;
        rate = (dsum == 0) ? 0 : num / dsum;
        if (rate > 128'hFFFF_FFFF_FFFF) rate = 128'hFFFF_FFFF_FFFF;
        base_vol = 32'(ema_next(48'(base_vol), 48'(v[31:0])));
        base_rate = ema_next(base_rate, rate[47:0]);
        prev_price = mid;
        prev_time = ts;
        m.primed = 1'b1;
        m.vol = v[31:0];
        m.rate = rate[47:0];
        m.avg_vol = base_vol;
        m.avg_rate = base_rate;
        m.regime = {m.vol > base_vol, m.rate > base_rate};
        return m;
    endfunction

    task automatic send_tick(logic [31:0] mid, logic [63:0] ts);
        if (idle_en) begin
            while ($urandom_range(99) < 30) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {ts, mid};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_q.insert(expected_q.size(), predict_metrics(mid, ts));
        i_s_axis_tvalid <= 1'b0;
        // block is busy for at least this cycle after a transfer
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic write_weight(logic [15:0] w);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        weight = w;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_metrics got, exp_m;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.primed = o_m_axis_tuser;
            {got.regime, got.avg_rate, got.avg_vol, got.rate, got.vol} =
                o_m_axis_tdata[161:0];
            if (expected_q.size() == 0) begin
                $error("unexpected transfer");
                errors++;
            end else begin
                exp_m = expected_q[0];
                expected_q.delete(0);
                if (got.primed !== exp_m.primed) begin
                    $error("primed exp %0d got %0d", exp_m.primed, got.primed); errors++;
                end
                if (got.vol !== exp_m.vol) begin
                    $error("volatility exp %0h got %0h", exp_m.vol, got.vol); errors++;
                end
                if (got.rate !== exp_m.rate) begin
                    $error("intensity exp %0h got %0h", exp_m.rate, got.rate); errors++;
                end
                if (got.avg_vol !== exp_m.avg_vol) begin
                    $error("vol_baseline exp %0h got %0h", exp_m.avg_vol, got.avg_vol);
                    errors++;
                end
                if (got.avg_rate !== exp_m.avg_rate) begin
                    $error("rate_baseline exp %0h got %0h", exp_m.avg_rate, got.avg_rate);
                    errors++;
                end
                if (got.regime !== exp_m.regime) begin
                    $error("regime exp %0d got %0d", exp_m.regime, got.regime); errors++;
                end
            end
        end
    end

    // sink stall
    always @(posedge i_clk) begin
        if (idle_en) i_m_axis_tready <= ($urandom_range(99) >= 30);
        else         i_m_axis_tready <= 1'b1;
    end

    task automatic test_directed();
        send_tick(32'd1000, 64'd0);
        send_tick(32'd1010, 64'd5000);
        send_tick(32'd1010, 64'd5000);              // zero elapsed time
        send_tick(32'hFFFF_FFFF, 64'd10000);        // huge positive return
        send_tick(32'd1, 64'd20000);                // negative return
        send_tick(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF); // saturated return, long gap
        send_tick(32'd5, 64'd3);                    // time runs backwards
        send_tick(32'd0, 64'd100);                  // zero price drops priming
        send_tick(32'd0, 64'd200);                  // stays unprimed
        send_tick(32'd77, 64'd300);
        send_tick(32'd78, 64'd301);
        for (int i = 0; i < 12; i++)
            send_tick(32'd78 + i, 64'd400 + i);
    endtask

    task automatic test_random(int count);
        logic [31:0] px;
        logic [63:0] ts;
        px = 32'd100000;
        ts = {$urandom, $urandom};
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(19))
                0: px = $urandom;
                1: px = 0;
                2: px = $urandom_range(3);
                default: px = px + $urandom_range(2000) - 1000;
            endcase
            case ($urandom_range(19))
                0: ts = {$urandom, $urandom};
                1: ts = ts - $urandom_range(1000);
                2: ;
                default: ts = ts + $urandom_range(5000000);
            endcase
            send_tick(px, ts);
        end
    endtask

    task automatic test_weights();
        write_weight(16'd0);
        test_random(100);
        write_weight(16'hFFFF);
        test_random(100);
        write_weight(16'd32768);
        test_random(100);
        write_weight(16'd655);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b1;
        weight = 16'd655;
        prev_price = 0;
        prev_time = 0;
        fill = 0;
        head = 0;
        base_vol = 0;
        base_rate = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(150);       // no idling
        idle_en = 1'b1;
        test_weights();
        test_random(830);
        wait_drained();
        if (errors == 0) $display("PASS rolling_volatility_regime_top");
        else $display("FAIL rolling_volatility_regime_top");
        $finish;
    end

    initial begin
        #40000000;
        $display("FAIL rolling_volatility_regime_top");
        $finish;
    end
endmodule
`default_nettype wire
